// File: design/ket_pkg.sv
package ket_pkg;

    // Fixed field widths of the request and response words.
    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    // Default table depth.
    localparam int DEF_ENTRIES = 16;

    // Request operation codes; the fourth code is unused and ignored.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_MOVE   = 2'd2
    } func_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_MOVED     = 3'd2,
        ST_ZERO_KEY  = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_FULL      = 3'd5,
        ST_NOT_FOUND = 3'd6
    } status_t;

    // Write command from the decision logic to the entry store.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_MOVE  = 2'd3
    } store_op_t;

endpackage

// File: design/ket_if.sv
// Request channel: one word per table operation.
interface ket_req_if import ket_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;

    modport source (output valid, func, key, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, func, key, pos_x, pos_y, pos_z, output ready);
endinterface

// Response channel: one status word per request.
interface ket_rsp_if import ket_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

// File: design/ket_store.sv
module ket_store import ket_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  store_op_t        op,
    input  logic [IDX_W-1:0] idx,
    input  logic [KEY_W-1:0] key,
    input  logic [POS_W-1:0] pos_x,
    input  logic [POS_W-1:0] pos_y,
    input  logic [POS_W-1:0] pos_z,
    output logic [ENTRIES-1:0] valid_vec,
    output logic [KEY_W-1:0] keys [ENTRIES]
);

    logic [ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]   key_reg   [ENTRIES];
    logic [POS_W-1:0]   pos_x_reg [ENTRIES];
    logic [POS_W-1:0]   pos_y_reg [ENTRIES];
    logic [POS_W-1:0]   pos_z_reg [ENTRIES];

    // Valid bits are the only control state; reset empties the table at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (op == OP_ADD)
        begin
            valid_reg[idx] <= 1'b1;
        end
        else if (op == OP_CLEAR)
        begin
            valid_reg[idx] <= 1'b0;
        end
    end

    // Keys and positions are payload. A key is only looked at while its slot
    // is valid, and an added slot always starts from a zero position.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_ADD:
            begin
                key_reg[idx]   <= key;
                pos_x_reg[idx] <= '0;
                pos_y_reg[idx] <= '0;
                pos_z_reg[idx] <= '0;
            end
            OP_CLEAR:
            begin
                key_reg[idx]   <= '0;
                pos_x_reg[idx] <= '0;
                pos_y_reg[idx] <= '0;
                pos_z_reg[idx] <= '0;
            end
            OP_MOVE:
            begin
                pos_x_reg[idx] <= pos_x;
                pos_y_reg[idx] <= pos_y;
                pos_z_reg[idx] <= pos_z;
            end
            default:
            begin
            end
        endcase
    end

    assign valid_vec = valid_reg;
    assign keys      = key_reg;

endmodule

// File: design/ket_lookup.sv
module ket_lookup import ket_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic [ENTRIES-1:0] valid_vec,
    input  logic [KEY_W-1:0]   keys [ENTRIES],
    input  logic [KEY_W-1:0]   key,
    output logic               hit,
    output logic [IDX_W-1:0]   hit_idx,
    output logic               free,
    output logic [IDX_W-1:0]   free_idx
);

    logic [ENTRIES-1:0] match_vec;

    // Parallel key compare against every valid slot.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_vec[i] && (keys[i] == key);
        end
    end

    // Priority encoders: the lowest matching slot and the lowest free slot win.
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!valid_vec[i])
            begin
                free     = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

endmodule

// File: design/keyed_entry_table.sv
// Keyed entry table: a store of ENTRIES slots, each with a 32-bit key and
// three 32-bit position words, looked up by key in one parallel compare.
// An add takes the lowest free slot, a remove clears the matching slot and a
// move overwrites its position; each request word yields one response word
// with a status code and the slot involved (slot index modulo 16). A request
// is held in an input register and resolved there against the table, which
// is updated on the same edge that loads the response register, so one
// request is taken every cycle while the response side keeps up, and each
// response word is presented from the response register once its request has
// passed the input register. A stalled response holds the request behind it.
// The table is empty after reset with no clearing pass.
module keyed_entry_table import ket_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic clk,
    input  logic rst_n,
    ket_req_if.sink   req,
    ket_rsp_if.source rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Input register.
    logic              in_valid_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [POS_W-1:0]  pos_x_reg;
    logic [POS_W-1:0]  pos_y_reg;
    logic [POS_W-1:0]  pos_z_reg;

    // Response register.
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;

    logic               advance;
    logic               accept;
    store_op_t          store_op;
    logic [IDX_W-1:0]   sel_idx;
    logic [IDX_W+SLOT_W-1:0] sel_idx_ext;
    logic [ENTRIES-1:0] valid_vec;
    logic [KEY_W-1:0]   keys [ENTRIES];
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               free;
    logic [IDX_W-1:0]   free_idx;

    // Handshake: the held request moves on when the response register is
    // empty or being emptied, and the input register refills in that cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= req.func;
            key_reg   <= req.key;
            pos_x_reg <= req.pos_x;
            pos_y_reg <= req.pos_y;
            pos_z_reg <= req.pos_z;
        end
    end

    // Table store and key search.
    ket_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (store_op),
        .idx       (sel_idx),
        .key       (key_reg),
        .pos_x     (pos_x_reg),
        .pos_y     (pos_y_reg),
        .pos_z     (pos_z_reg),
        .valid_vec (valid_vec),
        .keys      (keys)
    );

    ket_lookup #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_lookup (
        .valid_vec (valid_vec),
        .keys      (keys),
        .key       (key_reg),
        .hit       (hit),
        .hit_idx   (hit_idx),
        .free      (free),
        .free_idx  (free_idx)
    );

    // Decision: status, slot and the store write for the held request.
    always_comb
    begin
        status_next = ST_NOT_FOUND;
        sel_idx     = hit_idx;
        store_op    = OP_NONE;
        case (func_t'(func_reg))
            FUNC_ADD:
            begin
                if (key_reg == '0)
                begin
                    status_next = ST_ZERO_KEY;
                end
                else if (hit)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (free)
                begin
                    status_next = ST_ADDED;
                    sel_idx     = free_idx;
                    store_op    = advance ? OP_ADD : OP_NONE;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            FUNC_REMOVE:
            begin
                if (key_reg == '0)
                begin
                    status_next = ST_ZERO_KEY;
                end
                else if (hit)
                begin
                    status_next = ST_REMOVED;
                    store_op    = advance ? OP_CLEAR : OP_NONE;
                end
            end
            FUNC_MOVE:
            begin
                if (key_reg == '0)
                begin
                    status_next = ST_ZERO_KEY;
                end
                else if (hit)
                begin
                    status_next = ST_MOVED;
                    store_op    = advance ? OP_MOVE : OP_NONE;
                end
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    // The slot field reports the index only when a slot was used or matched.
    assign sel_idx_ext = {{SLOT_W{1'b0}}, sel_idx};
    always_comb
    begin
        case (status_next)
            ST_ADDED, ST_REMOVED, ST_MOVED, ST_DUPLICATE:
            begin
                slot_next = sel_idx_ext[SLOT_W-1:0];
            end
            default:
            begin
                slot_next = '0;
            end
        endcase
    end

    // Response register: loaded as the request advances, held while stalled.
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.slot   = slot_reg;

    // An add only ever lands in a slot that was free.
    a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
        store_op == OP_ADD |-> !valid_vec[sel_idx])
        else $error("add written over an occupied slot");

    // An add fills exactly one more slot.
    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        store_op == OP_ADD |=>
            $countones(valid_vec) == $past($countones(valid_vec)) + 1)
        else $error("add did not occupy exactly one slot");

    // A remove frees exactly one slot, the matched one.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        store_op == OP_CLEAR |-> valid_vec[sel_idx] ##1
            $countones(valid_vec) == $past($countones(valid_vec)) - 1)
        else $error("remove did not free exactly one slot");

    // The table is written only for a request that advances.
    a_write_advance: assert property (@(posedge clk) disable iff (!rst_n)
        store_op != OP_NONE |-> advance)
        else $error("table written without a request moving on");

    // With the response register empty the block always takes a request.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("request refused while the response register is empty");

endmodule

// File: sim/keyed_entry_table_checker.sv
`timescale 1ns / 100ps

// Watches the request and response channels of the keyed entry table, keeps
// a shadow copy of the table and checks every response word against the
// status and slot that the shadow copy says it must carry.
module keyed_entry_table_checker import ket_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic clk,
    input  logic rst_n,
    ket_req_if   req,
    ket_rsp_if   rsp,
    output int   error_count,
    output int   pending_count,
    output int   matched_count,
    output int   full_count
);

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } table_reply_t;

    // Shadow table and the replies still owed by the block.
    logic               shadow_used [ENTRIES];
    logic [KEY_W-1:0]   shadow_key  [ENTRIES];
    logic [3*POS_W-1:0] shadow_pos  [ENTRIES];
    table_reply_t       owed_replies [$];

    // Counts a failure and describes the first few of them.
    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endtask

    // Applies one request word to the shadow table and returns its reply.
    function automatic table_reply_t apply_request(
        input logic [FUNC_W-1:0] op,
        input logic [KEY_W-1:0]  key,
        input logic [POS_W-1:0]  x,
        input logic [POS_W-1:0]  y,
        input logic [POS_W-1:0]  z
    );
        table_reply_t reply;
        int           hit;
        int           free_slot;
        bit           known_op;

        hit       = -1;
        free_slot = -1;
        reply.status = ST_NOT_FOUND;
        reply.slot   = '0;
        known_op = (op == FUNC_ADD) || (op == FUNC_REMOVE) || (op == FUNC_MOVE);

        // Scanning downwards leaves the lowest matching and lowest free index.
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (shadow_used[i] && shadow_key[i] == key)
                hit = i;
            if (!shadow_used[i])
                free_slot = i;
        end

        if (known_op && key == '0)
        begin
            reply.status = ST_ZERO_KEY;
        end
        else
        begin
            case (op)
                FUNC_ADD:
                begin
                    if (hit >= 0)
                    begin
                        reply.status = ST_DUPLICATE;
                        reply.slot   = hit[SLOT_W-1:0];
                    end
                    else if (free_slot >= 0)
                    begin
                        shadow_used[free_slot] = 1'b1;
                        shadow_key[free_slot]  = key;
                        shadow_pos[free_slot]  = '0;
                        reply.status = ST_ADDED;
                        reply.slot   = free_slot[SLOT_W-1:0];
                    end
                    else
                    begin
                        reply.status = ST_FULL;
                    end
                end
                FUNC_REMOVE:
                begin
                    if (hit >= 0)
                    begin
                        shadow_used[hit] = 1'b0;
                        shadow_key[hit]  = '0;
                        shadow_pos[hit]  = '0;
                        reply.status = ST_REMOVED;
                        reply.slot   = hit[SLOT_W-1:0];
                    end
                end
                FUNC_MOVE:
                begin
                    if (hit >= 0)
                    begin
                        shadow_pos[hit] = {x, y, z};
                        reply.status = ST_MOVED;
                        reply.slot   = hit[SLOT_W-1:0];
                    end
                end
                default:
                begin
                    // The unused operation code changes nothing.
                end
            endcase
        end
        return reply;
    endfunction

    // Responses are checked before the request of the same edge is queued;
    // a response can never belong to a request accepted on the same edge.
    always @(posedge clk)
    begin
        table_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                shadow_used[i] = 1'b0;
                shadow_key[i]  = '0;
                shadow_pos[i]  = '0;
            end
            owed_replies.delete();
            pending_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (owed_replies.size() == 0)
                begin
                    report_mismatch("unrequested response word (status)", -1, rsp.status);
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", want.status, rsp.status);
                    if (rsp.slot !== want.slot)
                        report_mismatch("slot", want.slot, rsp.slot);
                    matched_count++;
                    if (want.status == ST_FULL)
                        full_count++;
                end
            end
            if (req.valid && req.ready)
            begin
                owed_replies.push_back(apply_request(req.func, req.key,
                                                     req.pos_x, req.pos_y, req.pos_z));
            end
            pending_count = owed_replies.size();
        end
    end

endmodule

// File: sim/keyed_entry_table_test.sv
`timescale 1ns / 100ps

module keyed_entry_table_test;
    import ket_pkg::*;

    localparam int ENTRIES      = DEF_ENTRIES;
    localparam int RANDOM_ITEMS = 450;
    localparam int POOL_DEPTH   = 32;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    int error_count;
    int pending_count;
    int matched_count;
    int full_count;
    int add_count;
    int remove_count;
    int move_count;
    int unused_count;

    // Keys that random traffic draws from, so that lookups often hit.
    logic [KEY_W-1:0] key_pool [POOL_DEPTH];
    int               pool_fill;
    bit               burst_mode;

    ket_req_if req_ch ();
    ket_rsp_if rsp_ch ();

    keyed_entry_table #(.ENTRIES(ENTRIES)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    keyed_entry_table_checker #(.ENTRIES(ENTRIES)) table_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .error_count   (error_count),
        .pending_count (pending_count),
        .matched_count (matched_count),
        .full_count    (full_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one; none at all in a burst.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Mostly keys from the first span entries of the pool, some fresh ones, rarely zero.
    function automatic logic [KEY_W-1:0] pick_key(input int span);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        if (roll < 16)
            return $urandom();
        return key_pool[$urandom_range(0, span - 1)];
    endfunction

    // Presents one request word and returns on the edge that accepts it,
    // leaving valid high so that the next word can follow without a gap.
    task automatic send_request(
        input logic [FUNC_W-1:0] op,
        input logic [KEY_W-1:0]  key,
        input logic [POS_W-1:0]  x,
        input logic [POS_W-1:0]  y,
        input logic [POS_W-1:0]  z
    );
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.key   <= key;
        req_ch.pos_x <= x;
        req_ch.pos_y <= y;
        req_ch.pos_z <= z;
        do
            @(posedge clk);
        while (!req_ch.ready);
        case (op)
            FUNC_ADD:    add_count++;
            FUNC_REMOVE: remove_count++;
            FUNC_MOVE:   move_count++;
            default:     unused_count++;
        endcase
    endtask

    // Adds a key and remembers it for the random traffic.
    task automatic add_pool_key(input logic [KEY_W-1:0] key);
        send_request(FUNC_ADD, key, pick_pos(), pick_pos(), pick_pos());
        key_pool[pool_fill] = key;
        pool_fill++;
    endtask

    // Stops sending until every owed response word has arrived.
    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        wait (pending_count == 0);
        @(posedge clk);
    endtask

    // Response side: runs of steady acceptance, short stalls and long stalls.
    initial
    begin
        int roll;
        int span;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                rsp_ch.ready <= 1'b1;
                span = $urandom_range(20, 60);
            end
            else if (roll < 65)
            begin
                rsp_ch.ready <= 1'b1;
                span = $urandom_range(1, 4);
            end
            else if (roll < 95)
            begin
                rsp_ch.ready <= 1'b0;
                span = $urandom_range(1, 3);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                span = $urandom_range(10, 30);
            end
            repeat (span) @(posedge clk);
        end
    end

    // Request side and verdict.
    initial
    begin
        int counted;
        int span;
        int block_len;
        int add_share;
        int roll;
        logic [FUNC_W-1:0] op;

        counted    = 0;
        pool_fill  = 0;
        burst_mode = 1'b0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FUNC_ADD;
        req_ch.key   <= '0;
        req_ch.pos_x <= '0;
        req_ch.pos_y <= '0;
        req_ch.pos_z <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero key on every operation, the unused code, misses on an empty table.
        send_request(FUNC_ADD, '0, '1, '1, '1);
        send_request(FUNC_REMOVE, '0, '1, '1, '1);
        send_request(FUNC_MOVE, '0, '1, '1, '1);
        send_request(FUNC_UNUSED, 32'h1234_5678, '1, '1, '1);
        send_request(FUNC_REMOVE, 32'hDEAD_BEEF, '0, '0, '0);
        send_request(FUNC_MOVE, 32'hDEAD_BEEF, '1, '1, '1);

        // Add, duplicate, move and remove on the lowest slots, then reuse of a hole.
        add_pool_key(32'hFFFF_FFFF);
        add_pool_key(32'h0000_0001);
        send_request(FUNC_ADD, 32'h0000_0001, '1, '1, '1);
        send_request(FUNC_MOVE, 32'h0000_0001, '1, '1, '1);
        send_request(FUNC_REMOVE, 32'h0000_0001, '1, '1, '1);
        add_pool_key(32'h0000_0002);

        // Fill the table, overflow it, then free a middle slot and take it again.
        for (int i = 2; i < ENTRIES; i++)
            add_pool_key(32'h0000_0100 + i);
        send_request(FUNC_ADD, 32'h5A5A_5A5A, '0, '0, '0);
        send_request(FUNC_REMOVE, 32'h0000_0107, '1, '1, '1);
        add_pool_key(32'h8000_0000);
        drain_replies();

        // The rest of the pool holds fresh non-zero keys.
        for (int i = pool_fill; i < POOL_DEPTH; i++)
            key_pool[i] = $urandom_range(1, 32'hFFFF_FFFF);

        // Random blocks, each with its own key window and add/remove balance,
        // so that the table swings between nearly empty and full.
        while (counted < RANDOM_ITEMS)
        begin
            span       = $urandom_range(4, POOL_DEPTH);
            add_share  = $urandom_range(15, 65);
            burst_mode = ($urandom_range(0, 3) == 0);
            block_len  = $urandom_range(30, 80);
            for (int n = 0; n < block_len && counted < RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = FUNC_UNUSED;
                else if (roll < 3 + add_share)
                    op = FUNC_ADD;
                else if (roll < 3 + add_share + (97 - add_share) / 2)
                    op = FUNC_REMOVE;
                else
                    op = FUNC_MOVE;
                send_request(op, pick_key(span), pick_pos(), pick_pos(), pick_pos());
                if (op != FUNC_UNUSED)
                    counted++;
            end
            burst_mode = 1'b0;
            if ($urandom_range(0, 2) == 0)
                drain_replies();
        end

        drain_replies();
        repeat (10) @(posedge clk);
        $display("Sent %0d adds, %0d removes, %0d moves and %0d words with the unused code.",
                 add_count, remove_count, move_count, unused_count);
        $display("Checked %0d response words, %0d of them table-full refusals.",
                 matched_count, full_count);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Timed out with %0d response words outstanding.", pending_count);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/ket_pkg.sv
design/ket_if.sv
design/ket_store.sv
design/ket_lookup.sv
design/keyed_entry_table.sv
sim/keyed_entry_table_checker.sv
sim/keyed_entry_table_test.sv
